@@ rtl/bpc_pkg.sv @@
// Shared types, constants and rounding helper for the pressure compensation block.
package bpc_pkg;

    // Output format
    localparam int OUT_FRAC_BITS = 12;
    localparam int OUT_W         = 23;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 64;

    // Division by 100 * 2^(24-OUT_FRAC_BITS) = 25 * 2^(26-OUT_FRAC_BITS)
    localparam int DIV_BASE = 25;
    localparam int DIV_SH   = 26 - OUT_FRAC_BITS;
    localparam int DIV_HALF = 50 * (2 ** (24 - OUT_FRAC_BITS));
    localparam int SAT_LIM  = DIV_BASE * (2 ** OUT_W);
    localparam int U_W      = $clog2(SAT_LIM);
    localparam int RECIP_SH = U_W + $clog2(DIV_BASE);
    localparam longint RECIP = ((64'd1 << RECIP_SH) + 64'(DIV_BASE) - 64'd1) / DIV_BASE;
    localparam int RECIP_W  = $clog2(RECIP);
    localparam int PROD_W   = U_W + RECIP_W;

    // Register index codes
    typedef enum logic [1:0] {
        REG_TEMP_CALIB = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_MID  = 2'd2,
        REG_PRESS_HIGH = 2'd3
    } bpc_reg_idx_t;

    // Unpacked calibration words
    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } bpc_cfg_t;

    // Linearized temperature and its powers, Q24, with the raw pressure
    typedef struct packed {
        logic [23:0]        pres;
        logic signed [35:0] lin;
        logic signed [45:0] lin2;
        logic signed [56:0] lin3;
    } bpc_lin_t;

    // Compensated pressure in Pa, Q24
    typedef logic signed [51:0] bpc_acc_t;

    // v / 2^n rounded to nearest, ties away from zero
    function automatic logic signed [127:0] rnd_half_away(input logic signed [127:0] v,
                                                          input int unsigned n);
        logic [127:0] m;
        logic [127:0] q;
        m = v[127] ? 128'(-v) : 128'(v);
        q = (m + (128'd1 << (n - 1))) >> n;
        return v[127] ? -$signed(q) : $signed(q);
    endfunction

endpackage

@@ rtl/bpc_if.sv @@
// Valid/ready channel interfaces for raw samples and compensated results.
interface bpc_meas_if;
    logic        valid;
    logic        ready;
    logic [23:0] adc_pressure;
    logic [23:0] adc_temperature;

    modport source (output valid, output adc_pressure, output adc_temperature, input ready);
    modport sink   (input valid, input adc_pressure, input adc_temperature, output ready);
endinterface

interface bpc_result_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pressure_hpa;
    logic             clipped;

    modport source (output valid, output pressure_hpa, output clipped, input ready);
    modport sink   (input valid, input pressure_hpa, input clipped, output ready);
endinterface

@@ rtl/bpc_cfg.sv @@
// APB register file holding the packed calibration words.
module bpc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::CFG_AW-1:0]  paddr,
    input  logic [bpc_pkg::CFG_DW-1:0]  pwdata,
    output logic [bpc_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output bpc_pkg::bpc_cfg_t           cfg
);
    import bpc_pkg::*;

    logic [39:0]  temp_calib_reg;
    logic [47:0]  press_low_reg;
    logic [47:0]  press_mid_reg;
    logic [31:0]  press_high_reg;
    bpc_reg_idx_t idx;
    logic         wr_en;

    assign pready = 1'b1;
    assign idx    = bpc_reg_idx_t'(paddr[CFG_AW-1:3]);
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TEMP_CALIB: temp_calib_reg <= pwdata[39:0];
                REG_PRESS_LOW:  press_low_reg  <= pwdata[47:0];
                REG_PRESS_MID:  press_mid_reg  <= pwdata[47:0];
                REG_PRESS_HIGH: press_high_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_TEMP_CALIB: prdata = {24'd0, temp_calib_reg};
            REG_PRESS_LOW:  prdata = {16'd0, press_low_reg};
            REG_PRESS_MID:  prdata = {16'd0, press_mid_reg};
            REG_PRESS_HIGH: prdata = {32'd0, press_high_reg};
            default:        prdata = '0;
        endcase
    end

    // Split the packed words into coefficients
    always_comb
    begin
        cfg.t1  = temp_calib_reg[15:0];
        cfg.t2  = temp_calib_reg[31:16];
        cfg.t3  = temp_calib_reg[39:32];
        cfg.p1  = press_low_reg[15:0];
        cfg.p2  = press_low_reg[31:16];
        cfg.p3  = press_low_reg[39:32];
        cfg.p4  = press_low_reg[47:40];
        cfg.p5  = press_mid_reg[15:0];
        cfg.p6  = press_mid_reg[31:16];
        cfg.p7  = press_mid_reg[39:32];
        cfg.p8  = press_mid_reg[47:40];
        cfg.p9  = press_high_reg[15:0];
        cfg.p10 = press_high_reg[23:16];
        cfg.p11 = press_high_reg[31:24];
    end

endmodule

@@ rtl/bpc_temp.sv @@
// Seven-stage pipeline: linearized temperature and its square and cube.
module bpc_temp (
    input  logic              clk,
    input  logic              rst_n,
    input  bpc_pkg::bpc_cfg_t cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [23:0]       up_pres,
    input  logic [23:0]       up_temp,
    output logic              dn_valid,
    input  logic              dn_ready,
    output bpc_pkg::bpc_lin_t dn_data
);
    import bpc_pkg::*;

    localparam int NS = 7;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic signed [25:0]  s1_d_reg;
    logic [23:0]         s1_p_reg;
    logic signed [42:0]  s2_a_reg;
    logic signed [49:0]  s2_dd_reg;
    logic [23:0]         s2_p_reg;
    logic signed [35:0]  s3_l_reg;
    logic [23:0]         s3_p_reg;
    logic signed [53:0]  s4_mh_reg;
    logic signed [54:0]  s4_ml_reg;
    logic signed [35:0]  s4_l_reg;
    logic [23:0]         s4_p_reg;
    logic signed [45:0]  s5_l2_reg;
    logic signed [35:0]  s5_l_reg;
    logic [23:0]         s5_p_reg;
    logic signed [63:0]  s6_nh_reg;
    logic signed [64:0]  s6_nl_reg;
    logic signed [45:0]  s6_l2_reg;
    logic signed [35:0]  s6_l_reg;
    logic [23:0]         s6_p_reg;
    bpc_lin_t            s7_reg;

    logic signed [25:0]  d_next;
    logic signed [42:0]  a_next;
    logic signed [49:0]  dd_next;
    logic signed [61:0]  x_val;
    logic signed [127:0] l_wide;
    logic signed [35:0]  l_next;
    logic signed [17:0]  lh4;
    logic signed [18:0]  ll4;
    logic signed [53:0]  mh_next;
    logic signed [54:0]  ml_next;
    logic signed [71:0]  sq_val;
    logic signed [127:0] l2_wide;
    logic signed [45:0]  l2_next;
    logic signed [17:0]  lh6;
    logic signed [18:0]  ll6;
    logic signed [63:0]  nh_next;
    logic signed [64:0]  nl_next;
    logic signed [83:0]  cu_val;
    logic signed [127:0] l3_wide;
    bpc_lin_t            s7_next;

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NS-1];
    assign dn_data  = s7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Datapath
    always_comb
    begin
        // offset from reference temperature
        d_next  = $signed({2'b00, up_temp}) - $signed({2'b00, cfg.t1, 8'h00});
        // linear and square terms
        a_next  = s1_d_reg * $signed({1'b0, cfg.t2});
        dd_next = s1_d_reg * s1_d_reg;
        // temp_lin in Q24
        x_val   = (62'(s2_a_reg) <<< 18) + s2_dd_reg * $signed(cfg.t3);
        l_wide  = rnd_half_away(128'(x_val), 24);
        l_next  = l_wide[35:0];
        // square, split on the second operand
        lh4     = s3_l_reg[35:18];
        ll4     = {1'b0, s3_l_reg[17:0]};
        mh_next = s3_l_reg * lh4;
        ml_next = s3_l_reg * ll4;
        sq_val  = (72'(s4_mh_reg) <<< 18) + 72'(s4_ml_reg);
        l2_wide = rnd_half_away(128'(sq_val), 24);
        l2_next = l2_wide[45:0];
        // cube, same split
        lh6     = s5_l_reg[35:18];
        ll6     = {1'b0, s5_l_reg[17:0]};
        nh_next = s5_l2_reg * lh6;
        nl_next = s5_l2_reg * ll6;
        cu_val  = (84'(s6_nh_reg) <<< 18) + 84'(s6_nl_reg);
        l3_wide = rnd_half_away(128'(cu_val), 24);
        s7_next.pres = s6_p_reg;
        s7_next.lin  = s6_l_reg;
        s7_next.lin2 = s6_l2_reg;
        s7_next.lin3 = l3_wide[56:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_d_reg <= d_next;
            s1_p_reg <= up_pres;
        end
        if (en[1])
        begin
            s2_a_reg  <= a_next;
            s2_dd_reg <= dd_next;
            s2_p_reg  <= s1_p_reg;
        end
        if (en[2])
        begin
            s3_l_reg <= l_next;
            s3_p_reg <= s2_p_reg;
        end
        if (en[3])
        begin
            s4_mh_reg <= mh_next;
            s4_ml_reg <= ml_next;
            s4_l_reg  <= s3_l_reg;
            s4_p_reg  <= s3_p_reg;
        end
        if (en[4])
        begin
            s5_l2_reg <= l2_next;
            s5_l_reg  <= s4_l_reg;
            s5_p_reg  <= s4_p_reg;
        end
        if (en[5])
        begin
            s6_nh_reg <= nh_next;
            s6_nl_reg <= nl_next;
            s6_l2_reg <= s5_l2_reg;
            s6_l_reg  <= s5_l_reg;
            s6_p_reg  <= s5_p_reg;
        end
        if (en[6])
        begin
            s7_reg <= s7_next;
        end
    end

endmodule

@@ rtl/bpc_poly.sv @@
// Five-stage pipeline: offset, sensitivity and quadratic terms, then the cubic in pressure.
module bpc_poly (
    input  logic              clk,
    input  logic              rst_n,
    input  bpc_pkg::bpc_cfg_t cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  bpc_pkg::bpc_lin_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output bpc_pkg::bpc_acc_t dn_data
);
    import bpc_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage 1: raw coefficient products
    logic signed [52:0] q1_o1_reg;
    logic signed [53:0] q1_o2_reg;
    logic signed [64:0] q1_o3_reg;
    logic signed [53:0] q1_s1_reg;
    logic signed [53:0] q1_s2_reg;
    logic signed [64:0] q1_s3_reg;
    logic signed [43:0] q1_q1_reg;
    logic [47:0]        q1_psq_reg;
    logic signed [32:0] q1_cp_reg;
    logic [23:0]        q1_p_reg;
    // stage 2: summed coefficients
    logic signed [48:0] q2_off_reg;
    logic signed [42:0] q2_sens_reg;
    logic signed [27:0] q2_quad_reg;
    logic signed [57:0] q2_wh_reg;
    logic signed [57:0] q2_wl_reg;
    logic [47:0]        q2_psq_reg;
    logic [23:0]        q2_p_reg;
    // stage 3: products with pressure
    logic signed [67:0] q3_sp_reg;
    logic signed [52:0] q3_qh_reg;
    logic signed [52:0] q3_ql_reg;
    logic signed [81:0] q3_cub_reg;
    logic signed [48:0] q3_off_reg;
    // stage 4: rounded terms
    logic signed [51:0] q4_sp_reg;
    logic signed [45:0] q4_q_reg;
    logic signed [40:0] q4_c_reg;
    logic signed [48:0] q4_off_reg;
    // stage 5: accumulated result
    bpc_acc_t           q5_acc_reg;

    logic signed [17:0]  p1m;
    logic signed [17:0]  p2m;
    logic signed [24:0]  pres_s;
    logic signed [52:0]  o1_next;
    logic signed [53:0]  o2_next;
    logic signed [64:0]  o3_next;
    logic signed [53:0]  s1_next;
    logic signed [53:0]  s2_next;
    logic signed [64:0]  s3_next;
    logic signed [43:0]  qq_next;
    logic [47:0]         psq_next;
    logic signed [32:0]  cp_next;
    logic signed [127:0] r_o1, r_o2, r_o3, r_s1, r_s2, r_s3, r_q1;
    logic signed [48:0]  off_next;
    logic signed [42:0]  sens_next;
    logic signed [27:0]  quad_next;
    logic signed [57:0]  wh_next;
    logic signed [57:0]  wl_next;
    logic signed [67:0]  sp_next;
    logic signed [52:0]  qh_next;
    logic signed [52:0]  ql_next;
    logic signed [81:0]  cub_next;
    logic signed [77:0]  qsum;
    logic signed [127:0] r_sp, r_q, r_c;
    bpc_acc_t            acc_next;

    // Stage enables
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NS-1];
    assign dn_data  = q5_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Datapath
    always_comb
    begin
        p1m    = $signed({{2{cfg.p1[15]}}, cfg.p1}) - 18'sd16384;
        p2m    = $signed({{2{cfg.p2[15]}}, cfg.p2}) - 18'sd16384;
        pres_s = $signed({1'b0, up_data.pres});

        // stage 1 products
        o1_next  = $signed({1'b0, cfg.p6}) * $signed(up_data.lin);
        o2_next  = $signed(cfg.p7) * $signed(up_data.lin2);
        o3_next  = $signed(cfg.p8) * $signed(up_data.lin3);
        s1_next  = p2m * $signed(up_data.lin);
        s2_next  = $signed(cfg.p3) * $signed(up_data.lin2);
        s3_next  = $signed(cfg.p4) * $signed(up_data.lin3);
        qq_next  = $signed(cfg.p10) * $signed(up_data.lin);
        psq_next = 48'(up_data.pres) * 48'(up_data.pres);
        cp_next  = pres_s * $signed(cfg.p11);

        // stage 2: round and sum the coefficient terms
        r_o1 = rnd_half_away(128'(q1_o1_reg), 6);
        r_o2 = rnd_half_away(128'(q1_o2_reg), 8);
        r_o3 = rnd_half_away(128'(q1_o3_reg), 15);
        r_s1 = rnd_half_away(128'(q1_s1_reg), 13);
        r_s2 = rnd_half_away(128'(q1_s2_reg), 16);
        r_s3 = rnd_half_away(128'(q1_s3_reg), 21);
        r_q1 = rnd_half_away(128'(q1_q1_reg), 16);
        off_next  = $signed({6'd0, cfg.p5, 27'd0}) + $signed(r_o1[48:0])
                  + $signed(r_o2[48:0]) + $signed(r_o3[48:0]);
        sens_next = $signed({{5{p1m[17]}}, p1m, 20'd0}) + $signed(r_s1[42:0])
                  + $signed(r_s2[42:0]) + $signed(r_s3[42:0]);
        quad_next = $signed({{4{cfg.p9[15]}}, cfg.p9, 8'd0}) + $signed(r_q1[27:0]);
        // cubic term: P^2 split in halves times P*p11
        wh_next = $signed({1'b0, q1_psq_reg[47:24]}) * q1_cp_reg;
        wl_next = $signed({1'b0, q1_psq_reg[23:0]}) * q1_cp_reg;

        // stage 3: products with pressure
        sp_next  = q2_sens_reg * $signed({1'b0, q2_p_reg});
        qh_next  = $signed({1'b0, q2_psq_reg[47:24]}) * q2_quad_reg;
        ql_next  = $signed({1'b0, q2_psq_reg[23:0]}) * q2_quad_reg;
        cub_next = (82'(q2_wh_reg) <<< 24) + 82'(q2_wl_reg);

        // stage 4: rounding
        qsum = (78'(q3_qh_reg) <<< 24) + 78'(q3_ql_reg);
        r_sp = rnd_half_away(128'(q3_sp_reg), 16);
        r_q  = rnd_half_away(128'(qsum), 32);
        r_c  = rnd_half_away(128'(q3_cub_reg), 41);

        // stage 5: final sum
        acc_next = 52'(q4_off_reg) + 52'(q4_sp_reg) + 52'(q4_q_reg) + 52'(q4_c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q1_o1_reg  <= o1_next;
            q1_o2_reg  <= o2_next;
            q1_o3_reg  <= o3_next;
            q1_s1_reg  <= s1_next;
            q1_s2_reg  <= s2_next;
            q1_s3_reg  <= s3_next;
            q1_q1_reg  <= qq_next;
            q1_psq_reg <= psq_next;
            q1_cp_reg  <= cp_next;
            q1_p_reg   <= up_data.pres;
        end
        if (en[1])
        begin
            q2_off_reg  <= off_next;
            q2_sens_reg <= sens_next;
            q2_quad_reg <= quad_next;
            q2_wh_reg   <= wh_next;
            q2_wl_reg   <= wl_next;
            q2_psq_reg  <= q1_psq_reg;
            q2_p_reg    <= q1_p_reg;
        end
        if (en[2])
        begin
            q3_sp_reg  <= sp_next;
            q3_qh_reg  <= qh_next;
            q3_ql_reg  <= ql_next;
            q3_cub_reg <= cub_next;
            q3_off_reg <= q2_off_reg;
        end
        if (en[3])
        begin
            q4_sp_reg  <= r_sp[51:0];
            q4_q_reg   <= r_q[45:0];
            q4_c_reg   <= r_c[40:0];
            q4_off_reg <= q3_off_reg;
        end
        if (en[4])
        begin
            q5_acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/bpc_out.sv @@
// Three-stage pipeline: scale Pa Q24 to hPa, round and saturate.
module bpc_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  bpc_pkg::bpc_acc_t          up_data,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [bpc_pkg::OUT_W-1:0]  dn_pressure,
    output logic                       dn_clipped
);
    import bpc_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic              o1_neg_reg;
    logic              o1_over_reg;
    logic              o1_small_reg;
    logic [U_W-1:0]    o1_u_reg;
    logic              o2_neg_reg;
    logic              o2_over_reg;
    logic              o2_small_reg;
    logic [PROD_W-1:0] o2_prod_reg;
    logic [OUT_W-1:0]  o3_pres_reg;
    logic              o3_clip_reg;

    logic [51:0]       mag;
    logic [52:0]       shifted;
    logic              over_next;
    logic              small_next;
    logic [PROD_W-1:0] prod_next;
    logic [OUT_W-1:0]  quot;
    logic [OUT_W-1:0]  pres_next;
    logic              clip_next;

    // Stage enables
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign up_ready    = en[0];
    assign dn_valid    = vld_reg[NS-1];
    assign dn_pressure = o3_pres_reg;
    assign dn_clipped  = o3_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Datapath
    always_comb
    begin
        // magnitude, add half the divisor, drop the power-of-two part
        mag        = up_data[51] ? 52'(-up_data) : 52'(up_data);
        shifted    = ({1'b0, mag} + 53'(DIV_HALF)) >> DIV_SH;
        over_next  = shifted >= 53'(SAT_LIM);
        small_next = shifted < 53'(DIV_BASE);
        // divide by 25 through the reciprocal
        prod_next  = PROD_W'(o1_u_reg) * PROD_W'(RECIP);
        quot       = o2_prod_reg[RECIP_SH +: OUT_W];
        // saturate: below zero to zero, above range to full scale
        if (o2_neg_reg)
        begin
            pres_next = '0;
            clip_next = !o2_small_reg;
        end
        else if (o2_over_reg)
        begin
            pres_next = {OUT_W{1'b1}};
            clip_next = 1'b1;
        end
        else
        begin
            pres_next = quot;
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            o1_neg_reg   <= up_data[51];
            o1_over_reg  <= over_next;
            o1_small_reg <= small_next;
            o1_u_reg     <= shifted[U_W-1:0];
        end
        if (en[1])
        begin
            o2_neg_reg   <= o1_neg_reg;
            o2_over_reg  <= o1_over_reg;
            o2_small_reg <= o1_small_reg;
            o2_prod_reg  <= prod_next;
        end
        if (en[2])
        begin
            o3_pres_reg <= pres_next;
            o3_clip_reg <= clip_next;
        end
    end

endmodule

@@ rtl/baro_pressure_compensation_top.sv @@
// Top level of the barometric pressure compensation pipeline.
// Takes one raw pressure/temperature word per cycle on meas and returns the
// compensated pressure in hPa (OUT_FRAC_BITS fraction bits, saturated with a
// clipped flag) on result, one word per accepted sample and in order. Samples
// pass through the linearized temperature and its square and cube, the
// polynomial, then scaling and saturation. Throughput is one word per
// cycle; the pipeline stalls only when result is not ready and every stage is
// full, and empty stages keep absorbing samples meanwhile. Calibration words
// are written over APB at byte addresses 0, 8, 16 and 24 and must only change
// while no sample is in flight.
module baro_pressure_compensation_top (
    input  logic                        clk,
    input  logic                        rst_n,
    bpc_meas_if.sink                    meas,
    bpc_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::CFG_AW-1:0]  paddr,
    input  logic [bpc_pkg::CFG_DW-1:0]  pwdata,
    output logic [bpc_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import bpc_pkg::*;

    bpc_cfg_t cfg;
    logic     lin_valid;
    logic     lin_ready;
    bpc_lin_t lin_data;
    logic     acc_valid;
    logic     acc_ready;
    bpc_acc_t acc_data;

    // Calibration registers
    bpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Temperature linearization
    bpc_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (meas.valid),
        .up_ready (meas.ready),
        .up_pres  (meas.adc_pressure),
        .up_temp  (meas.adc_temperature),
        .dn_valid (lin_valid),
        .dn_ready (lin_ready),
        .dn_data  (lin_data)
    );

    // Pressure polynomial
    bpc_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (lin_valid),
        .up_ready (lin_ready),
        .up_data  (lin_data),
        .dn_valid (acc_valid),
        .dn_ready (acc_ready),
        .dn_data  (acc_data)
    );

    // Scaling and saturation
    bpc_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (acc_valid),
        .up_ready    (acc_ready),
        .up_data     (acc_data),
        .dn_valid    (result.valid),
        .dn_ready    (result.ready),
        .dn_pressure (result.pressure_hpa),
        .dn_clipped  (result.clipped)
    );

    // Input only backs up when the result side is holding a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !meas.ready |-> (result.valid && !result.ready))
        else $error("input stalled without output back-pressure");

    // A clipped word sits at one end of the range
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.clipped) |->
        (result.pressure_hpa == '0 || result.pressure_hpa == {OUT_W{1'b1}}))
        else $error("clipped word not at range limit");

endmodule

@@ verif/bpc_checker.sv @@
// Checker: mirrors the calibration registers, predicts each compensated pressure and compares.
`timescale 1ns / 100ps

module bpc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    bpc_meas_if                        meas,
    bpc_result_if                      result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::CFG_AW-1:0] paddr,
    input  logic [bpc_pkg::CFG_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         fails,
    output int                         pending
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] hpa;
        logic             clip;
    } hpa_word_t;

    localparam logic signed [127:0] MAG_LIM = 128'sh7FFF_FFFF_FFFF_FFFF;

    logic [39:0] temp_cal;
    logic [47:0] press_lo;
    logic [47:0] press_mid;
    logic [31:0] press_hi;

    hpa_word_t hpa_expected_q[$];

    // a*b / 2^n, nearest with ties away from zero, magnitude clamped to 63 bits
    function automatic longint scaled_prod(input longint a, input longint b, input int n);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] prod;
        logic signed [127:0] m;
        pa = a;
        pb = b;
        prod = pa * pb;
        m = (prod < 0) ? -prod : prod;
        if (n > 0)
            m = (m + (128'sd1 <<< (n - 1))) >>> n;
        if (m > MAG_LIM)
            m = MAG_LIM;
        return (prod < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic hpa_word_t compensate(input logic [23:0] praw_v, input logic [23:0] traw_v);
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint praw, d, x, lin, lin2, lin3, offs, sens, quad, psq, acc;
        longint unsigned amag, q, dv;
        hpa_word_t w;
        t1  = longint'(temp_cal[15:0]);
        t2  = longint'(temp_cal[31:16]);
        t3  = longint'($signed(temp_cal[39:32]));
        p1  = longint'($signed(press_lo[15:0]));
        p2  = longint'($signed(press_lo[31:16]));
        p3  = longint'($signed(press_lo[39:32]));
        p4  = longint'($signed(press_lo[47:40]));
        p5  = longint'(press_mid[15:0]);
        p6  = longint'(press_mid[31:16]);
        p7  = longint'($signed(press_mid[39:32]));
        p8  = longint'($signed(press_mid[47:40]));
        p9  = longint'($signed(press_hi[15:0]));
        p10 = longint'($signed(press_hi[23:16]));
        p11 = longint'($signed(press_hi[31:24]));
        praw = longint'(praw_v);

        // linearized temperature, Q24
        d    = longint'(traw_v) - 256 * t1;
        x    = d * t2 * 262144 + d * d * t3;
        lin  = scaled_prod(x, 1, 24);
        lin2 = scaled_prod(lin, lin, 24);
        lin3 = scaled_prod(lin2, lin, 24);

        // cubic polynomial
        offs = p5 * 134217728 + scaled_prod(p6, lin, 6) + scaled_prod(p7, lin2, 8)
             + scaled_prod(p8, lin3, 15);
        sens = (p1 - 16384) * 1048576 + scaled_prod(p2 - 16384, lin, 13)
             + scaled_prod(p3, lin2, 16) + scaled_prod(p4, lin3, 21);
        quad = p9 * 256 + scaled_prod(p10, lin, 16);
        psq  = praw * praw;
        acc  = offs + scaled_prod(sens, praw, 16) + scaled_prod(psq, quad, 32)
             + scaled_prod(psq * p11, praw, 41);

        // Pa Q24 to hPa with OUT_FRAC_BITS fraction bits, saturated
        dv   = 64'd100 << (24 - OUT_FRAC_BITS);
        amag = (acc < 0) ? longint'(-acc) : longint'(acc);
        q    = (amag + dv / 2) / dv;
        w.clip = 1'b0;
        if (acc < 0) begin
            w.hpa  = '0;
            w.clip = (q != 0);
        end
        else if (q > 64'h7F_FFFF) begin
            w.hpa  = '1;
            w.clip = 1'b1;
        end
        else
            w.hpa = q[OUT_W-1:0];
        return w;
    endfunction

    assign pending = hpa_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        hpa_word_t exp_w;
        if (!rst_n) begin
            temp_cal  <= '0;
            press_lo  <= '0;
            press_mid <= '0;
            press_hi  <= '0;
            fails     <= 0;
            hpa_expected_q.delete();
        end
        else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (bpc_reg_idx_t'(paddr[4:3]))
                    REG_TEMP_CALIB: temp_cal  <= pwdata[39:0];
                    REG_PRESS_LOW:  press_lo  <= pwdata[47:0];
                    REG_PRESS_MID:  press_mid <= pwdata[47:0];
                    REG_PRESS_HIGH: press_hi  <= pwdata[31:0];
                    default: ;
                endcase
            end
            // accepted sample
            if (meas.valid && meas.ready)
                hpa_expected_q.push_back(compensate(meas.adc_pressure, meas.adc_temperature));
            // accepted result
            if (result.valid && result.ready) begin
                if (hpa_expected_q.size() == 0) begin
                    if (fails < 10)
                        $display("result word with nothing expected: hpa=%0h clip=%0b",
                                 result.pressure_hpa, result.clipped);
                    fails <= fails + 1;
                end
                else begin
                    exp_w = hpa_expected_q.pop_front();
                    if (exp_w.hpa !== result.pressure_hpa || exp_w.clip !== result.clipped) begin
                        if (fails < 10)
                            $display("mismatch: expected hpa=%0h clip=%0b, got hpa=%0h clip=%0b",
                                     exp_w.hpa, exp_w.clip, result.pressure_hpa,
                                     result.clipped);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/baro_pressure_compensation_top_tb.sv @@
// Testbench top: clock, reset, calibration writes, sample stimulus and verdict.
`timescale 1ns / 100ps

module baro_pressure_compensation_top_tb;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIM = 5000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    int                fails;
    int                pending;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                quiet_cycles;

    bpc_meas_if   meas_ch ();
    bpc_result_if res_ch ();

    baro_pressure_compensation_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpc_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .fails   (fails),
        .pending (pending)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // result back-pressure
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIM) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // APB write, called at a falling edge
    task automatic cfg_write(input bpc_reg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // send one sample word, called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic [23:0] pres, input logic [23:0] temp);
        while ($urandom_range(99) < tx_idle_pct) begin
            meas_ch.valid <= 1'b0;
            @(negedge clk);
        end
        meas_ch.valid           <= 1'b1;
        meas_ch.adc_pressure    <= pres;
        meas_ch.adc_temperature <= temp;
        do
            @(posedge clk);
        while (!meas_ch.ready);
        @(negedge clk);
    endtask

    // wait for every expected word, then let the pipeline settle
    task automatic drain();
        meas_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        logic [63:0] tcal, plo, pmid, phi;
        logic [23:0] tnom;
        int n_rand;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 14;
        rx_idle_pct = 70;
        meas_ch.valid           = 1'b0;
        meas_ch.adc_pressure    = '0;
        meas_ch.adc_temperature = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 6; ph++) begin
            // idling pattern: sender light first, then receiver light, then none
            case (ph / 2)
                0: begin tx_idle_pct = 14; rx_idle_pct = 70; end
                1: begin tx_idle_pct = 70; rx_idle_pct = 14; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph)
                0: begin tcal = '0; plo = '0; pmid = '0; phi = '0; end
                1: begin tcal = '1; plo = '1; pmid = '1; phi = '1; end
                2: begin
                    // plausible sensor trim
                    tcal = 64'h00_F9_4A00_6B00;
                    plo  = 64'h0A_F2_FFD0_FB4E;
                    pmid = 64'h0F_0A_7622_0003;
                    phi  = 64'h00_00_01_2E_1B4C;
                end
                3: begin
                    // signed minima, unsigned maxima, with t1 at zero
                    tcal = 64'h80_FFFF_0000;
                    plo  = 64'h8080_8000_8000;
                    pmid = 64'h8080_FFFF_FFFF;
                    phi  = 64'h8080_8000;
                end
                default: begin
                    tcal = {$urandom, $urandom};
                    plo  = {$urandom, $urandom};
                    pmid = {$urandom, $urandom};
                    phi  = {$urandom, $urandom};
                end
            endcase
            cfg_write(REG_TEMP_CALIB, tcal);
            cfg_write(REG_PRESS_LOW, plo);
            cfg_write(REG_PRESS_MID, pmid);
            cfg_write(REG_PRESS_HIGH, phi);
            tnom = {tcal[15:0], 8'h00};

            // directed corners
            if (ph == 1 || ph == 2 || ph == 3) begin
                send_sample(24'h000000, 24'h000000);
                send_sample(24'hFFFFFF, 24'hFFFFFF);
                send_sample(24'hFFFFFF, 24'h000000);
                send_sample(24'h000000, 24'hFFFFFF);
                send_sample(24'h800000, 24'h800000);
                send_sample(24'h6B0000, tnom);
            end

            // random samples, mostly near the trimmed temperature point
            n_rand = 92;
            for (int i = 0; i < n_rand; i++) begin
                if ($urandom_range(3) == 0)
                    send_sample(24'($urandom), 24'($urandom));
                else
                    send_sample(24'($urandom_range(24'hFFFFFF, 24'h400000)),
                                tnom + 24'($signed(18'($urandom))));
            end
            drain();
        end

        if (fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
